FILE: rtl/core/pem_pkg.sv
// pem_pkg: shared types and constants of the pulse energy meter.
// No dependencies; used by every module of the block.
package pem_pkg;

	// fixed field widths
	localparam int POWER_W = 32;
	localparam int COUNT_W = 32;
	localparam int TODAY_W = 42;
	localparam int TOTAL_W = 48;
	localparam int DAY_W   = 3;
	localparam int PPWH_W  = 14;
	localparam int COOL_W  = 8;
	localparam int CFG_W   = 14;
	localparam int CFG_IDX_W = 1;

	// shared divider: power dividend is left aligned, divisor up to 32x14 bits
	localparam int NUM_W  = 42;
	localparam int DEN_W  = 46;
	localparam int STEP_W = 6;

	localparam logic [STEP_W-1:0] PWR_STEPS = STEP_W'(POWER_W);
	localparam logic [STEP_W-1:0] NRG_STEPS = STEP_W'(NUM_W);

	localparam logic [31:0] POWER_NUM  = 32'd3600000000;
	localparam logic [9:0]  MWH_PER_WH = 10'd1000;

	localparam logic [PPWH_W-1:0] PPWH_RST = PPWH_W'(1);
	localparam logic [COOL_W-1:0] COOL_RST = COOL_W'(20);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PPWH     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 1'b1;

	// func codes
	localparam logic FUNC_PULSE = 1'b0;
	localparam logic FUNC_DAY   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_PWR_GO,
		ST_PWR_WAIT,
		ST_NRG_GO,
		ST_NRG_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic day_roll;
		logic first_pulse;
		logic count_pulse;
		logic prep;
		logic div_start;
		logic div_nrg;
		logic take_pwr;
		logic take_nrg;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_day;
		logic day_diff;
		logic first;
		logic flicker;
		logic div_done;
	} sts_t;

endpackage

FILE: rtl/core/pem_div.sv
// pem_div: restoring divider, one quotient bit per cycle.
// Depends on pem_pkg; used by pem_datapath for both power and energy.
module pem_div
	import pem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [STEP_W-1:0] steps,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [DEN_W-1:0]  divisor,
	output logic              done,
	output logic [NUM_W-1:0]  quotient
);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	// quotient bits enter at the bottom of the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: rtl/core/pem_datapath.sv
// pem_datapath: meter state, config registers, arithmetic and result register.
// Depends on pem_pkg and pem_div; driven by pem_ctrl commands.
module pem_datapath
	import pem_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 func,
	input  logic [TIME_BITS-1:0] time_ms,
	input  logic [DAY_W-1:0]     weekday,
	output logic                 counted,
	output logic                 rolled_over,
	output logic [POWER_W-1:0]   power_mw,
	output logic [COUNT_W-1:0]   pulse_count,
	output logic [TODAY_W-1:0]   today_mwh,
	output logic [TODAY_W-1:0]   yesterday_mwh,
	output logic [TOTAL_W-1:0]   total_mwh
);

	localparam int DW = (TIME_BITS > 32) ? TIME_BITS : 32;

	// config
	logic [PPWH_W-1:0] ppwh_q;
	logic [COOL_W-1:0] cool_q;
	logic [PPWH_W-1:0] p_eff;

	// captured input word
	logic                 func_q;
	logic [TIME_BITS-1:0] time_q;
	logic [DAY_W-1:0]     day_in_q;

	// meter state
	logic                 awaiting_q;
	logic [TIME_BITS-1:0] last_q;
	logic [COUNT_W-1:0]   count_q;
	logic [POWER_W-1:0]   power_q;
	logic [TODAY_W-1:0]   today_q;
	logic [TODAY_W-1:0]   yest_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [DAY_W-1:0]     day_q;

	// per-word flags and operands
	logic               counted_q;
	logic               rolled_q;
	logic               long_q;
	logic [31:0]        dt32_q;
	logic [DEN_W-1:0]   prod_q;
	logic [NUM_W-1:0]   nrg_num_q;

	// result register
	logic               o_counted_q;
	logic               o_rolled_q;
	logic [POWER_W-1:0] o_power_q;
	logic [COUNT_W-1:0] o_count_q;
	logic [TODAY_W-1:0] o_today_q;
	logic [TODAY_W-1:0] o_yest_q;
	logic [TOTAL_W-1:0] o_total_q;

	logic [TIME_BITS-1:0] dt;
	logic [DW-1:0]        dt_w;
	logic                 long_gap;
	logic [TOTAL_W:0]     total_sum;
	logic [NUM_W-1:0]     div_dividend;
	logic [DEN_W-1:0]     div_divisor;
	logic [STEP_W-1:0]    div_steps;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quot;

	assign p_eff    = (ppwh_q == '0) ? PPWH_W'(1) : ppwh_q;
	assign dt       = time_q - last_q;
	assign dt_w     = DW'(dt);
	assign long_gap = (dt_w > DW'(POWER_NUM));
	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(today_q);

	assign sts.is_day   = (func_q == FUNC_DAY);
	assign sts.day_diff = (day_in_q != day_q);
	assign sts.first    = awaiting_q;
	assign sts.flicker  = (dt <= TIME_BITS'(cool_q));
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppwh_q <= PPWH_RST;
			cool_q <= COOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PPWH:     ppwh_q <= cfg_data[PPWH_W-1:0];
				REG_COOLDOWN: cool_q <= cfg_data[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= func;
			time_q   <= time_ms;
			day_in_q <= weekday;
		end
		if (cmd.count_pulse) begin
			long_q <= long_gap;
			dt32_q <= long_gap ? 32'd0 : dt_w[31:0];
		end
		if (cmd.prep) begin
			prod_q    <= DEN_W'(dt32_q) * DEN_W'(p_eff);
			nrg_num_q <= NUM_W'(count_q) * NUM_W'(MWH_PER_WH);
		end
		if (cmd.load_out) begin
			o_counted_q <= counted_q;
			o_rolled_q  <= rolled_q;
			o_power_q   <= power_q;
			o_count_q   <= count_q;
			o_today_q   <= today_q;
			o_yest_q    <= yest_q;
			o_total_q   <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			last_q     <= '0;
			count_q    <= '0;
			power_q    <= '0;
			today_q    <= '0;
			yest_q     <= '0;
			total_q    <= '0;
			day_q      <= '0;
			counted_q  <= 1'b0;
			rolled_q   <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				counted_q <= 1'b0;
				rolled_q  <= 1'b0;
			end
			if (cmd.first_pulse) begin
				awaiting_q <= 1'b0;
				last_q     <= time_q;
			end
			if (cmd.count_pulse) begin
				counted_q <= 1'b1;
				count_q   <= count_q + 1'b1;
				last_q    <= time_q;
			end
			if (cmd.day_roll) begin
				rolled_q <= 1'b1;
				day_q    <= day_in_q;
				yest_q   <= today_q;
				total_q  <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
				today_q  <= '0;
				count_q  <= '0;
			end
			if (cmd.take_pwr)
				power_q <= long_q ? '0 : div_quot[POWER_W-1:0];
			if (cmd.take_nrg)
				today_q <= div_quot[TODAY_W-1:0];
		end
	end

	// power dividend sits in the top bits so only PWR_STEPS steps are needed
	assign div_dividend = cmd.div_nrg ? nrg_num_q
	                                  : {POWER_NUM, {(NUM_W-32){1'b0}}};
	assign div_divisor  = cmd.div_nrg ? DEN_W'(p_eff) : prod_q;
	assign div_steps    = cmd.div_nrg ? NRG_STEPS : PWR_STEPS;

	pem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.steps    (div_steps),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign counted       = o_counted_q;
	assign rolled_over   = o_rolled_q;
	assign power_mw      = o_power_q;
	assign pulse_count   = o_count_q;
	assign today_mwh     = o_today_q;
	assign yesterday_mwh = o_yest_q;
	assign total_mwh     = o_total_q;

endmodule

FILE: rtl/core/pem_ctrl.sv
// pem_ctrl: sequencing state machine and handshake control.
// Depends on pem_pkg; commands pem_datapath.
module pem_ctrl
	import pem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (sts.is_day || sts.first || sts.flicker)
					state_d = ST_FINISH;
				else
					state_d = ST_PREP;
			end
			ST_PREP:     state_d = ST_PWR_GO;
			ST_PWR_GO:   state_d = ST_PWR_WAIT;
			ST_PWR_WAIT: if (sts.div_done) state_d = ST_NRG_GO;
			ST_NRG_GO:   state_d = ST_NRG_WAIT;
			ST_NRG_WAIT: if (sts.div_done) state_d = ST_FINISH;
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_EVAL: begin
				if (sts.is_day)
					cmd.day_roll = sts.day_diff;
				else if (sts.first)
					cmd.first_pulse = 1'b1;
				else if (!sts.flicker)
					cmd.count_pulse = 1'b1;
			end
			ST_PREP:     cmd.prep = 1'b1;
			ST_PWR_GO:   cmd.div_start = 1'b1;
			ST_PWR_WAIT: cmd.take_pwr = sts.div_done;
			ST_NRG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_nrg   = 1'b1;
			end
			ST_NRG_WAIT: begin
				cmd.div_nrg  = 1'b1;
				cmd.take_nrg = sts.div_done;
			end
			ST_FINISH:   cmd.load_out = out_free;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/pulse_energy_meter.sv
// pulse_energy_meter: top level of the LED pulse energy meter.
// Depends on pem_pkg, pem_ctrl and pem_datapath.
//
// Takes one word at a time. A day poll, the first pulse and a flicker pulse
// go from ST_EVAL straight to ST_FINISH, which loads the result register
// once it is free; a counted pulse first passes ST_PREP and two runs of the
// single shared restoring divider, which runs 32 steps for power
// (3600000000 / (dt * pulses_per_wh)) and then 42 steps for today's energy
// (count * 1000 / pulses_per_wh), one quotient bit a cycle. The next word is
// taken only after the result register has been loaded.
// The result sits in an output register, so the next word is accepted while
// a finished result still waits for out_ready. Config writes on cfg_we are
// taken at any edge but are meant to happen only while the block is idle;
// a pulses_per_wh of 0 acts as 1. time_ms is TIME_BITS wide and wraps.
module pulse_energy_meter
	import pem_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [TIME_BITS-1:0] time_ms,
	input  logic [DAY_W-1:0]     weekday,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 counted,
	output logic                 rolled_over,
	output logic [POWER_W-1:0]   power_mw,
	output logic [COUNT_W-1:0]   pulse_count,
	output logic [TODAY_W-1:0]   today_mwh,
	output logic [TODAY_W-1:0]   yesterday_mwh,
	output logic [TOTAL_W-1:0]   total_mwh
);

	cmd_t cmd;
	sts_t sts;

	// control: handshakes and the pulse / division sequence
	pem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: meter state, divider and the result register
	pem_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.time_ms       (time_ms),
		.weekday       (weekday),
		.counted       (counted),
		.rolled_over   (rolled_over),
		.power_mw      (power_mw),
		.pulse_count   (pulse_count),
		.today_mwh     (today_mwh),
		.yesterday_mwh (yesterday_mwh),
		.total_mwh     (total_mwh)
	);

endmodule

FILE: rtl/core/pem_checker.sv
// pem_port_checks: port-level assertions for pulse_energy_meter, bound below.
// Depends on pem_pkg.
module pem_port_checks
	import pem_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               counted,
	input logic               rolled_over,
	input logic [POWER_W-1:0] power_mw,
	input logic [COUNT_W-1:0] pulse_count,
	input logic [TODAY_W-1:0] today_mwh
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_mw)
		&& $stable(pulse_count) && $stable(today_mwh))
		else $error("result word changed while stalled");

	// one word at a time: an accepted word drops in_ready in the cycle after acceptance
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in flight");

	// a word is never both a counted pulse and a rollover
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(counted && rolled_over))
		else $error("counted and rolled_over both set");

	// a new day starts from zero
	a_roll_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rolled_over |-> pulse_count == '0 && today_mwh == '0)
		else $error("rollover left count or energy");

endmodule

bind pulse_energy_meter pem_port_checks u_pem_port_checks (.*);
